@@ design/idmap_pkg.sv @@
// ----------------------------------------------------------------------------
// idmap_pkg
// Shared widths, opcodes, status codes and controller/datapath link types
// for the two-phase key-to-row map.
// ----------------------------------------------------------------------------
package idmap_pkg;

    localparam int OPW   = 3;
    localparam int KEYW  = 64;
    localparam int ROWW  = 10;
    localparam int STW   = 4;
    localparam int LIVEW = 9;

    localparam logic [OPW-1:0] OP_RESERVE  = 3'd0;
    localparam logic [OPW-1:0] OP_COMMIT   = 3'd1;
    localparam logic [OPW-1:0] OP_ROLLBACK = 3'd2;
    localparam logic [OPW-1:0] OP_ERASE    = 3'd3;
    localparam logic [OPW-1:0] OP_FIND     = 3'd4;
    localparam logic [OPW-1:0] OP_LABEL    = 3'd5;

    localparam logic [STW-1:0] ST_OK        = 4'd0;
    localparam logic [STW-1:0] ST_RESKEY    = 4'd1;
    localparam logic [STW-1:0] ST_PENDING   = 4'd2;
    localparam logic [STW-1:0] ST_PRESENT   = 4'd3;
    localparam logic [STW-1:0] ST_NOT_FOUND = 4'd4;
    localparam logic [STW-1:0] ST_NO_RESV   = 4'd5;
    localparam logic [STW-1:0] ST_FULL      = 4'd6;
    localparam logic [STW-1:0] ST_ROW_ORDER = 4'd7;
    localparam logic [STW-1:0] ST_ROW_RANGE = 4'd8;

    typedef struct packed {
        logic load;
        logic scan;
        logic rd;
        logic exec;
    } idmap_cmd_t;

    typedef struct packed {
        logic scan_last;
    } idmap_stat_t;

endpackage

@@ design/idmap_ctrl.sv @@
// ----------------------------------------------------------------------------
// idmap_ctrl
// Sequencer: latch beat, scan key table, flush compare, read rows, execute.
// ----------------------------------------------------------------------------
module idmap_ctrl
    import idmap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  idmap_stat_t stat,
    output logic        busy,
    output idmap_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_READ,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_SCAN;
            S_SCAN:  if (stat.scan_last) state_next = S_FLUSH;
            S_FLUSH: state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign cmd.load = (state_reg == S_IDLE) && start;
    assign cmd.scan = (state_reg == S_SCAN);
    assign cmd.rd   = (state_reg == S_READ);
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

@@ design/idmap_dp.sv @@
// ----------------------------------------------------------------------------
// idmap_dp
// Key table memories, valid/pending bits, row-label store, counters and
// result registers.
// ----------------------------------------------------------------------------
module idmap_dp
    import idmap_pkg::*;
#(
    parameter int MAP_ENTRIES  = 256,
    parameter int ROW_CAPACITY = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  idmap_cmd_t       cmd,
    output idmap_stat_t      stat,
    input  logic             cfg_wr,
    input  logic [KEYW-1:0]  cfg_data,
    input  logic [OPW-1:0]   opcode,
    input  logic [KEYW-1:0]  external_key,
    input  logic             allow_replace,
    input  logic [ROWW-1:0]  row_index,
    output logic             done,
    output logic [STW-1:0]   status,
    output logic [ROWW-1:0]  row_out,
    output logic             row_out_valid,
    output logic [KEYW-1:0]  label_out,
    output logic [LIVEW-1:0] live_keys
);

    localparam int SW = $clog2(MAP_ENTRIES);
    localparam int RW = $clog2(ROW_CAPACITY + 1);
    localparam int AW = $clog2(ROW_CAPACITY);
    localparam int LW = $clog2(MAP_ENTRIES + 1);
    localparam int CW = (RW > ROWW) ? RW : ROWW;
    localparam logic [RW-1:0] ROW_NONE = RW'(ROW_CAPACITY);

    logic [KEYW-1:0]        rkey_reg;
    logic [OPW-1:0]         op_reg;
    logic [KEYW-1:0]        key_reg;
    logic                   repl_reg;
    logic [ROWW-1:0]        row_reg;

    logic [MAP_ENTRIES-1:0] used_reg;
    logic [MAP_ENTRIES-1:0] pend_reg;
    logic [KEYW-1:0]        key_mem   [MAP_ENTRIES];
    logic [RW-1:0]          row_mem   [MAP_ENTRIES];
    logic [KEYW-1:0]        label_mem [ROW_CAPACITY];

    logic [SW-1:0]          idx_reg;
    logic [SW-1:0]          cmp_idx_reg;
    logic                   cmp_vld_reg;
    logic [KEYW-1:0]        key_q_reg;
    logic                   hit_reg;
    logic [SW-1:0]          hit_slot_reg;
    logic                   free_reg;
    logic [SW-1:0]          free_slot_reg;
    logic [RW-1:0]          erow_q_reg;
    logic [KEYW-1:0]        label_q_reg;
    logic [RW-1:0]          next_row_reg;
    logic [LW-1:0]          live_reg;

    logic                   done_reg;
    logic [STW-1:0]         status_reg;
    logic [ROWW-1:0]        row_out_reg;
    logic                   rv_reg;
    logic [KEYW-1:0]        label_reg;

    logic [STW-1:0]         status_next;
    logic [ROWW-1:0]        row_out_next;
    logic                   rv_next;
    logic [KEYW-1:0]        label_next;
    logic                   res_new;
    logic                   set_pend;
    logic                   clr_pend;
    logic                   clr_used;
    logic                   commit_wr;
    logic                   live_inc;
    logic                   live_dec;
    logic                   pend_hit;
    logic                   has_row;
    logic                   order_bad;
    logic                   range_bad;
    logic                   rmem_we;
    logic [SW-1:0]          rmem_addr;
    logic [RW-1:0]          rmem_data;

    assign stat.scan_last = (idx_reg == SW'(MAP_ENTRIES - 1));

    assign pend_hit  = pend_reg[hit_slot_reg];
    assign has_row   = (erow_q_reg != ROW_NONE);
    assign order_bad = (CW'(row_reg) != CW'(next_row_reg)) || (next_row_reg >= ROW_NONE);
    assign range_bad = (CW'(row_reg) >= CW'(next_row_reg))
                    || (CW'(row_reg) >= CW'(ROW_CAPACITY));

    always_comb
    begin
        status_next  = ST_OK;
        row_out_next = '0;
        rv_next      = 1'b0;
        label_next   = '0;
        res_new      = 1'b0;
        set_pend     = 1'b0;
        clr_pend     = 1'b0;
        clr_used     = 1'b0;
        commit_wr    = 1'b0;
        live_inc     = 1'b0;
        live_dec     = 1'b0;
        case (op_reg)
            OP_RESERVE:
            begin
                if (key_reg == rkey_reg)
                    status_next = ST_RESKEY;
                else if (hit_reg)
                begin
                    if (pend_hit)
                        status_next = ST_PENDING;
                    else if (!repl_reg)
                        status_next = ST_PRESENT;
                    else
                    begin
                        set_pend = 1'b1;
                        if (has_row)
                        begin
                            row_out_next = ROWW'(erow_q_reg);
                            rv_next      = 1'b1;
                        end
                    end
                end
                else if (!free_reg)
                    status_next = ST_FULL;
                else
                    res_new = 1'b1;
            end
            OP_COMMIT:
            begin
                if (order_bad)
                    status_next = ST_ROW_ORDER;
                else if (!hit_reg || !pend_hit)
                    status_next = ST_NO_RESV;
                else
                begin
                    commit_wr = 1'b1;
                    clr_pend  = 1'b1;
                    if (has_row)
                    begin
                        row_out_next = ROWW'(erow_q_reg);
                        rv_next      = 1'b1;
                    end
                    else
                        live_inc = 1'b1;
                end
            end
            OP_ROLLBACK:
            begin
                if (!hit_reg || !pend_hit)
                    status_next = ST_NO_RESV;
                else
                begin
                    clr_pend = 1'b1;
                    clr_used = !has_row;
                end
            end
            OP_ERASE:
            begin
                if (!hit_reg || !has_row)
                    status_next = ST_NOT_FOUND;
                else if (pend_hit)
                    status_next = ST_PENDING;
                else
                begin
                    row_out_next = ROWW'(erow_q_reg);
                    rv_next      = 1'b1;
                    clr_used     = 1'b1;
                    live_dec     = (live_reg != '0);
                end
            end
            OP_FIND:
            begin
                if (!hit_reg || !has_row)
                    status_next = ST_NOT_FOUND;
                else
                begin
                    row_out_next = ROWW'(erow_q_reg);
                    rv_next      = 1'b1;
                end
            end
            OP_LABEL:
            begin
                if (range_bad)
                    status_next = ST_ROW_RANGE;
                else
                    label_next = label_q_reg;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign rmem_we   = cmd.exec && (res_new || commit_wr);
    assign rmem_addr = res_new ? free_slot_reg : hit_slot_reg;
    assign rmem_data = res_new ? ROW_NONE : next_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rkey_reg      <= '1;
            used_reg      <= '0;
            pend_reg      <= '0;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            hit_slot_reg  <= '0;
            free_reg      <= 1'b0;
            free_slot_reg <= '0;
            next_row_reg  <= '0;
            live_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
                rkey_reg <= cfg_data;
            done_reg    <= cmd.exec;
            cmp_vld_reg <= cmd.scan;
            if (cmd.load)
            begin
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (cmd.scan)
                idx_reg <= idx_reg + 1'b1;
            if (cmp_vld_reg)
            begin
                if (!hit_reg && used_reg[cmp_idx_reg] && (key_q_reg == key_reg))
                begin
                    hit_reg      <= 1'b1;
                    hit_slot_reg <= cmp_idx_reg;
                end
                if (!free_reg && !used_reg[cmp_idx_reg])
                begin
                    free_reg      <= 1'b1;
                    free_slot_reg <= cmp_idx_reg;
                end
            end
            if (cmd.exec)
            begin
                if (res_new)
                begin
                    used_reg[free_slot_reg] <= 1'b1;
                    pend_reg[free_slot_reg] <= 1'b1;
                end
                if (set_pend)
                    pend_reg[hit_slot_reg] <= 1'b1;
                if (clr_pend)
                    pend_reg[hit_slot_reg] <= 1'b0;
                if (clr_used)
                    used_reg[hit_slot_reg] <= 1'b0;
                if (commit_wr)
                    next_row_reg <= next_row_reg + 1'b1;
                if (live_inc)
                    live_reg <= live_reg + 1'b1;
                else if (live_dec)
                    live_reg <= live_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            key_reg  <= external_key;
            repl_reg <= allow_replace;
            row_reg  <= row_index;
        end
        if (cmd.scan)
        begin
            key_q_reg   <= key_mem[idx_reg];
            cmp_idx_reg <= idx_reg;
        end
        if (cmd.rd)
        begin
            erow_q_reg  <= row_mem[hit_slot_reg];
            label_q_reg <= label_mem[AW'(row_reg)];
        end
        if (cmd.exec && res_new)
            key_mem[free_slot_reg] <= key_reg;
        if (rmem_we)
            row_mem[rmem_addr] <= rmem_data;
        if (cmd.exec && commit_wr)
            label_mem[AW'(next_row_reg)] <= key_reg;
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            row_out_reg <= row_out_next;
            rv_reg      <= rv_next;
            label_reg   <= label_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign row_out       = row_out_reg;
    assign row_out_valid = rv_reg;
    assign label_out     = label_reg;
    assign live_keys     = LIVEW'(live_reg);

endmodule

@@ design/two_phase_id_map_table_top.sv @@
// ----------------------------------------------------------------------------
// two_phase_id_map_table_top
// Two-phase key-to-row map: reserve, commit, rollback, erase, find, label.
//
//   channel  handshake             payload
//   in       start / busy          opcode, external_key, allow_replace, row_index
//   result   done (1-cycle strobe) status, row_out, row_out_valid, label_out,
//                                  live_keys
//   cfg      cfg_valid / cfg_ready cfg_data (reserved key)
//
// Each beat runs through the states in order: the key table memory is scanned
// one entry per cycle, then a flush state empties the compare, a read state
// reads the row and label memories and an execute state executes.
// done pulses the cycle after execute; busy is already low then.
// Reset clears valid/pending bits and counters; memories are not cleared.
// The receiver cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
module two_phase_id_map_table_top
    import idmap_pkg::*;
#(
    parameter int MAP_ENTRIES  = 256,
    parameter int ROW_CAPACITY = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [OPW-1:0]   opcode,
    input  logic [KEYW-1:0]  external_key,
    input  logic             allow_replace,
    input  logic [ROWW-1:0]  row_index,
    output logic             done,
    output logic [STW-1:0]   status,
    output logic [ROWW-1:0]  row_out,
    output logic             row_out_valid,
    output logic [KEYW-1:0]  label_out,
    output logic [LIVEW-1:0] live_keys,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [KEYW-1:0]  cfg_data
);

    idmap_cmd_t  cmd;
    idmap_stat_t stat;

    assign cfg_ready = 1'b1;

    idmap_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    idmap_dp #(
        .MAP_ENTRIES  (MAP_ENTRIES),
        .ROW_CAPACITY (ROW_CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .external_key  (external_key),
        .allow_replace (allow_replace),
        .row_index     (row_index),
        .done          (done),
        .status        (status),
        .row_out       (row_out),
        .row_out_valid (row_out_valid),
        .label_out     (label_out),
        .live_keys     (live_keys)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe outside end of beat");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_fail_no_row: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK) && (status != ST_PENDING)) |-> !row_out_valid)
        else $error("failed op returned a row");

endmodule
